// ----- design/skt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and constants of the sorted key table: record layout, the
// operation and status codes, the cell commands and the sequencer state.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int KEY_W  = 27;
    localparam int HEAD_W = 64;
    localparam int TAIL_W = 8;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_LOOKUP = 3'd2,
        OP_ASC    = 3'd3,
        OP_DESC   = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    // What every cell of the row does in a given cycle.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CMP,
        CELL_INS,
        CELL_DEL,
        CELL_ASC,
        CELL_DESC
    } cell_cmd_t;

    // Which cell the record selector picks.
    typedef enum logic [1:0] {
        SEL_MATCH,
        SEL_FIRST,
        SEL_LAST
    } sel_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPLY,
        S_READ,
        S_EMPTY
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [HEAD_W-1:0] head;
        logic [TAIL_W-1:0] tail;
    } record_t;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        cell_cmd_t cell_cmd;
        sel_t      sel;
        logic      emit;
        status_t   status;
        logic      zero;
        logic      last;
    } skt_ctrl_t;

endpackage

// ----- design/skt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_cell
// One cell of the table row: holds a single record, compares it against the
// search key and takes a record from a neighbour when the row shifts or
// rotates.
// ----------------------------------------------------------------------------
module skt_cell
    import skt_pkg::*;
(
    input  logic             clk,
    input  cell_cmd_t        cmd,
    input  logic             occ,
    input  logic             is_last,
    input  logic [KEY_W-1:0] cmp_key,
    input  record_t          new_rec,
    input  record_t          left_rec,
    input  record_t          right_rec,
    input  record_t          wrap_rec,
    input  logic             left_lt,
    output record_t          rec,
    output logic             lt,
    output logic             match
);

    record_t rec_reg;
    record_t rec_next;
    logic    lt_reg;
    logic    lt_next;
    logic    eq_reg;
    logic    eq_next;

    // Next record and compare flags.
    always_comb
    begin
        rec_next = rec_reg;
        lt_next  = lt_reg;
        eq_next  = eq_reg;
        case (cmd)
            CELL_CMP:
            begin
                lt_next = occ && (rec_reg.key < cmp_key);
                eq_next = (rec_reg.key == cmp_key);
            end
            CELL_INS:
            begin
                // Cells at or after the insertion point move one place right;
                // the one just after the last smaller key takes the new item.
                if (!lt_reg)
                begin
                    rec_next = left_lt ? new_rec : left_rec;
                end
            end
            CELL_DEL:
            begin
                if (!lt_reg)
                begin
                    rec_next = right_rec;
                end
            end
            CELL_ASC:
            begin
                if (occ)
                begin
                    rec_next = is_last ? wrap_rec : right_rec;
                end
            end
            CELL_DESC:
            begin
                if (occ)
                begin
                    rec_next = left_rec;
                end
            end
            default:
            begin
                rec_next = rec_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
        lt_reg  <= lt_next;
        eq_reg  <= eq_next;
    end

    // The first matching cell is the one whose left neighbour is still smaller.
    assign match = occ && eq_reg && !lt_reg && left_lt;
    assign rec   = rec_reg;
    assign lt    = lt_reg;

endmodule

// ----- design/skt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_ctrl
// Sequencer of the sorted key table: accepts one item at a time, keeps the
// record count and steps the cell row through compare, update and read-out.
// ----------------------------------------------------------------------------
module skt_ctrl
    import skt_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [2:0]       opcode,
    input  logic             found,
    input  logic             out_free,
    output logic             in_ready,
    output logic [CNT_W-1:0] count,
    output skt_ctrl_t        ctrl
);

    localparam logic [CNT_W-1:0] Full = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] One  = CNT_W'(1);

    state_t           state_reg;
    state_t           state_next;
    logic [2:0]       op_reg;
    logic [2:0]       op_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] remain_reg;
    logic [CNT_W-1:0] remain_next;
    logic             accept;

    assign accept = in_valid && in_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == OP_INSERT || opcode == OP_DELETE || opcode == OP_LOOKUP)
                    begin
                        state_next = S_APPLY;
                    end
                    else if (opcode == OP_ASC || opcode == OP_DESC)
                    begin
                        state_next = (count_reg == '0) ? S_EMPTY : S_READ;
                    end
                end
            end
            S_APPLY, S_EMPTY:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                if (out_free && remain_reg == One)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs to the cell row and the output register.
    always_comb
    begin
        in_ready      = 1'b0;
        ctrl.cell_cmd = CELL_HOLD;
        ctrl.sel      = SEL_MATCH;
        ctrl.emit     = 1'b0;
        ctrl.status   = ST_OK;
        ctrl.zero     = 1'b1;
        ctrl.last     = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.cell_cmd = CELL_CMP;
                end
            end
            S_APPLY:
            begin
                ctrl.emit = out_free;
                if (op_reg == OP_INSERT)
                begin
                    if (count_reg == Full)
                    begin
                        ctrl.status = ST_FULL;
                    end
                    else if (out_free)
                    begin
                        ctrl.cell_cmd = CELL_INS;
                    end
                end
                else if (found)
                begin
                    ctrl.zero = 1'b0;
                    if (out_free && op_reg == OP_DELETE)
                    begin
                        ctrl.cell_cmd = CELL_DEL;
                    end
                end
                else
                begin
                    ctrl.status = ST_NOT_FOUND;
                end
            end
            S_EMPTY:
            begin
                ctrl.emit   = out_free;
                ctrl.status = ST_EMPTY;
            end
            S_READ:
            begin
                ctrl.emit = out_free;
                ctrl.zero = 1'b0;
                ctrl.last = (remain_reg == One);
                ctrl.sel  = (op_reg == OP_ASC) ? SEL_FIRST : SEL_LAST;
                if (out_free)
                begin
                    ctrl.cell_cmd = (op_reg == OP_ASC) ? CELL_ASC : CELL_DESC;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Operation, record count and read-out counter.
    always_comb
    begin
        op_next     = op_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        if (accept)
        begin
            op_next     = opcode;
            remain_next = count_reg;
        end
        if (ctrl.cell_cmd == CELL_INS)
        begin
            count_next = count_reg + One;
        end
        else if (ctrl.cell_cmd == CELL_DEL)
        begin
            count_next = count_reg - One;
        end
        else if (ctrl.cell_cmd == CELL_ASC || ctrl.cell_cmd == CELL_DESC)
        begin
            remain_next = remain_reg - One;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        remain_reg <= remain_next;
    end

    assign count = count_reg;

endmodule

// ----- design/sorted_key_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table
// Bounded table of records kept in ascending key order, built as a row of
// cells with one record each, with insert, delete, lookup and read-outs.
// ----------------------------------------------------------------------------
// The table takes one item at a time. For insert, delete and lookup every
// cell compares its key with the item's key in the cycle the item is
// accepted; once the output register is free, a successful insert or delete
// shifts the row one place and the result goes to the output register. On a
// read-out the occupied cells rotate one place each cycle that the output is
// free, and the record at the head of the row (ascending) or in the last
// occupied cell (descending) is delivered, so after the last record the
// table is back in its original order. A stalled output holds the sequencer.
// No clearing pass is needed; reset clears only the count, state and out_valid.
// ----------------------------------------------------------------------------
module sorted_key_table
    import skt_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int NAME_BYTES  = 9
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        opcode,
    input  logic [KEY_W-1:0]  key,
    input  logic [HEAD_W-1:0] name_head,
    input  logic [TAIL_W-1:0] name_tail,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [KEY_W-1:0]  out_key,
    output logic [HEAD_W-1:0] out_name_head,
    output logic [TAIL_W-1:0] out_name_tail,
    output logic              last
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [HEAD_W-1:0] HeadMask = (NAME_BYTES >= 8) ? {HEAD_W{1'b1}} :
        ~((64'd1 << (64 - 8 * NAME_BYTES)) - 64'd1);
    localparam logic [TAIL_W-1:0] TailMask = (NAME_BYTES >= 9) ? {TAIL_W{1'b1}} : '0;

    skt_ctrl_t        ctrl;
    logic [CNT_W-1:0] count;
    logic             out_free;
    logic             found;
    record_t          new_rec_reg;
    record_t          new_rec_next;
    record_t          sel_rec;
    record_t          cell_rec  [TABLE_DEPTH];
    logic             cell_lt   [TABLE_DEPTH];
    logic             cell_match[TABLE_DEPTH];
    logic             cell_occ  [TABLE_DEPTH];
    logic             cell_last [TABLE_DEPTH];

    logic             out_valid_reg;
    logic             out_valid_next;
    status_t          status_reg;
    record_t          out_rec_reg;
    logic             last_reg;

    assign out_free = !out_valid_reg || out_ready;

    // Sequencer.
    skt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .found    (found),
        .out_free (out_free),
        .in_ready (in_ready),
        .count    (count),
        .ctrl     (ctrl)
    );

    // The item's record, with name bytes beyond the name length cleared.
    always_comb
    begin
        new_rec_next = new_rec_reg;
        if (in_valid && in_ready)
        begin
            new_rec_next.key  = key;
            new_rec_next.head = name_head & HeadMask;
            new_rec_next.tail = name_tail & TailMask;
        end
    end

    always_ff @(posedge clk)
    begin
        new_rec_reg <= new_rec_next;
    end

    // Row of cells.
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        assign cell_occ[i]  = (CNT_W'(i) < count);
        assign cell_last[i] = (CNT_W'(i + 1) == count);

        skt_cell u_cell (
            .clk       (clk),
            .cmd       (ctrl.cell_cmd),
            .occ       (cell_occ[i]),
            .is_last   (cell_last[i]),
            .cmp_key   (key),
            .new_rec   (new_rec_reg),
            .left_rec  ((i == 0) ? sel_rec : cell_rec[(i == 0) ? 0 : i - 1]),
            .right_rec ((i == TABLE_DEPTH - 1) ? sel_rec :
                        cell_rec[(i == TABLE_DEPTH - 1) ? i : i + 1]),
            .wrap_rec  (sel_rec),
            .left_lt   ((i == 0) ? 1'b1 : cell_lt[(i == 0) ? 0 : i - 1]),
            .rec       (cell_rec[i]),
            .lt        (cell_lt[i]),
            .match     (cell_match[i])
        );
    end

    // Record selector: the first match, the head of the row or its last
    // occupied cell, combined as an AND-OR over the cells.
    always_comb
    begin
        sel_rec = '0;
        found   = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            found = found | cell_match[i];
            case (ctrl.sel)
                SEL_MATCH:
                begin
                    if (cell_match[i])
                    begin
                        sel_rec = sel_rec | cell_rec[i];
                    end
                end
                SEL_FIRST:
                begin
                    if (i == 0)
                    begin
                        sel_rec = sel_rec | cell_rec[i];
                    end
                end
                SEL_LAST:
                begin
                    if (cell_last[i])
                    begin
                        sel_rec = sel_rec | cell_rec[i];
                    end
                end
                default:
                begin
                    sel_rec = sel_rec;
                end
            endcase
        end
    end

    // Output register.
    assign out_valid_next = ctrl.emit || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            status_reg  <= ctrl.status;
            out_rec_reg <= ctrl.zero ? '0 : sel_rec;
            last_reg    <= ctrl.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign out_key       = out_rec_reg.key;
    assign out_name_head = out_rec_reg.head;
    assign out_name_tail = out_rec_reg.tail;
    assign last          = last_reg;

endmodule

// ----- test/sorted_key_table_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_test
// Self-checking bench for the sorted key table. A queue of pending items feeds
// a clocked driver, and a shadow table beside the block predicts every result.
// A monitor compares each delivered result with the oldest prediction. The
// stimulus is a directed opening followed by random items in three phases:
// fill up, mixed traffic, and drain down.
// ----------------------------------------------------------------------------
module sorted_key_table_test;
    import skt_pkg::*;

    localparam int TABLE_DEPTH  = 32;
    localparam int NAME_BYTES   = 9;
    localparam int RANDOM_ITEMS = 180;
    localparam int IDLE_PCT     = 36;
    localparam int HOLD_AT      = 60;
    localparam int HOLD_CYCLES  = 250;
    localparam int QUIET_FROM   = 120;
    localparam int QUIET_TO     = 170;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_LIMIT  = 40;
    localparam int POOL_STEP    = 6666666;

    // Opcodes that the block ignores.
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_MID   = 3'd6;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    localparam logic [HEAD_W-1:0] HEAD_KEEP = (NAME_BYTES >= 8) ? {HEAD_W{1'b1}} :
        ~((64'd1 << (64 - 8 * NAME_BYTES)) - 64'd1);
    localparam logic [TAIL_W-1:0] TAIL_KEEP = (NAME_BYTES >= 9) ? {TAIL_W{1'b1}} : '0;

    typedef struct packed {
        logic [2:0]        op;
        logic [KEY_W-1:0]  key;
        logic [HEAD_W-1:0] head;
        logic [TAIL_W-1:0] tail;
    } table_item_t;

    typedef struct packed {
        status_t           st;
        logic [KEY_W-1:0]  key;
        logic [HEAD_W-1:0] head;
        logic [TAIL_W-1:0] tail;
        logic              fin;
    } table_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [2:0]        opcode = '0;
    logic [KEY_W-1:0]  key = '0;
    logic [HEAD_W-1:0] name_head = '0;
    logic [TAIL_W-1:0] name_tail = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [1:0]        status;
    logic [KEY_W-1:0]  out_key;
    logic [HEAD_W-1:0] out_name_head;
    logic [TAIL_W-1:0] out_name_tail;
    logic              last;

    table_item_t   pending_items[$];
    table_result_t awaited_results[$];
    table_item_t   drive_item;
    table_item_t   taken_item;
    table_result_t want;

    // Shadow copy of the table contents.
    logic [KEY_W-1:0]  shadow_key[TABLE_DEPTH];
    logic [HEAD_W-1:0] shadow_head[TABLE_DEPTH];
    logic [TAIL_W-1:0] shadow_tail[TABLE_DEPTH];
    int                shadow_count = 0;

    logic in_taken = 1'b0;
    int   items_taken = 0;
    int   results_seen = 0;
    int   mismatches = 0;
    int   cycle_count = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;
    logic quiet;

    sorted_key_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NAME_BYTES  (NAME_BYTES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .key           (key),
        .name_head     (name_head),
        .name_tail     (name_tail),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .out_key       (out_key),
        .out_name_head (out_name_head),
        .out_name_tail (out_name_tail),
        .last          (last)
    );

    always #4 clk = ~clk;

    // Both sides run without gaps through this stretch of items.
    assign quiet = (items_taken >= QUIET_FROM) && (items_taken < QUIET_TO);

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        begin
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("MISMATCH at result %0d, %s: got %h, want %h",
                         results_seen, what, got, exp_val);
        end
    endtask

    task automatic add_item(input logic [2:0] op, input logic [KEY_W-1:0] k,
                            input logic [HEAD_W-1:0] h, input logic [TAIL_W-1:0] t);
        table_item_t it;
        begin
            it.op   = op;
            it.key  = k;
            it.head = h;
            it.tail = t;
            pending_items.push_back(it);
        end
    endtask

    // Computes the results of one operation and updates the shadow table.
    task automatic apply_table_op(input table_item_t it);
        table_result_t r;
        int pos;
        int j;
        int idx;
        begin
            r     = '0;
            r.fin = 1'b1;
            pos   = 0;
            while (pos < shadow_count && shadow_key[pos] < it.key)
                pos++;
            case (it.op)
                OP_INSERT:
                begin
                    if (shadow_count >= TABLE_DEPTH) begin
                        r.st = ST_FULL;
                    end
                    else begin
                        for (j = shadow_count; j > pos; j--) begin
                            shadow_key[j]  = shadow_key[j-1];
                            shadow_head[j] = shadow_head[j-1];
                            shadow_tail[j] = shadow_tail[j-1];
                        end
                        shadow_key[pos]  = it.key;
                        shadow_head[pos] = it.head & HEAD_KEEP;
                        shadow_tail[pos] = it.tail & TAIL_KEEP;
                        shadow_count++;
                        r.st = ST_OK;
                    end
                    awaited_results.push_back(r);
                end
                OP_DELETE, OP_LOOKUP:
                begin
                    if (pos >= shadow_count || shadow_key[pos] != it.key) begin
                        r.st = ST_NOT_FOUND;
                    end
                    else begin
                        r.st   = ST_OK;
                        r.key  = shadow_key[pos];
                        r.head = shadow_head[pos];
                        r.tail = shadow_tail[pos];
                        if (it.op == OP_DELETE) begin
                            for (j = pos; j + 1 < shadow_count; j++) begin
                                shadow_key[j]  = shadow_key[j+1];
                                shadow_head[j] = shadow_head[j+1];
                                shadow_tail[j] = shadow_tail[j+1];
                            end
                            shadow_count--;
                        end
                    end
                    awaited_results.push_back(r);
                end
                OP_ASC, OP_DESC:
                begin
                    if (shadow_count == 0) begin
                        r.st = ST_EMPTY;
                        awaited_results.push_back(r);
                    end
                    else begin
                        for (j = 0; j < shadow_count; j++) begin
                            idx    = (it.op == OP_ASC) ? j : shadow_count - 1 - j;
                            r.st   = ST_OK;
                            r.key  = shadow_key[idx];
                            r.head = shadow_head[idx];
                            r.tail = shadow_tail[idx];
                            r.fin  = (j + 1 == shadow_count);
                            awaited_results.push_back(r);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    endtask

    // Keys mostly come from a small pool so that deletes and lookups hit.
    function automatic logic [KEY_W-1:0] pick_key();
        logic [31:0] raw;
        begin
            if ($urandom_range(0, 3) == 0)
                raw = $urandom;
            else
                raw = $urandom_range(0, 15) * POOL_STEP;
            return raw[KEY_W-1:0];
        end
    endfunction

    // Operation mix by phase: filling, mixed, then draining.
    function automatic logic [2:0] pick_op(input int n);
        int r;
        int w_ins;
        int w_del;
        int w_look;
        int w_asc;
        begin
            r = $urandom_range(0, 99);
            if (n < 80) begin
                w_ins = 75; w_del = 83; w_look = 91; w_asc = 96;
            end
            else if (n < 150) begin
                w_ins = 30; w_del = 55; w_look = 78; w_asc = 89;
            end
            else begin
                w_ins = 10; w_del = 65; w_look = 80; w_asc = 90;
            end
            if (r < w_ins)
                return OP_INSERT;
            else if (r < w_del)
                return OP_DELETE;
            else if (r < w_look)
                return OP_LOOKUP;
            else if (r < w_asc)
                return OP_ASC;
            return OP_DESC;
        end
    endfunction

    // Input acceptance: the shadow table moves on every accepted item.
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready) begin
            taken_item.op   = opcode;
            taken_item.key  = key;
            taken_item.head = name_head;
            taken_item.tail = name_tail;
            apply_table_op(taken_item);
            items_taken <= items_taken + 1;
        end
    end

    // Driver: presents the next pending item, with random gaps.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken)) begin
            if (pending_items.size() != 0 &&
                (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                drive_item = pending_items.pop_front();
                opcode    <= drive_item.op;
                key       <= drive_item.key;
                name_head <= drive_item.head;
                name_tail <= drive_item.tail;
                in_valid  <= 1'b1;
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off that backs up the input.
    always @(negedge clk)
    begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (!hold_done && items_taken >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Monitor: each delivered result against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected result, key", 64'(out_key), '0);
            end
            else begin
                want = awaited_results.pop_front();
                if (status !== want.st)
                    report_mismatch("status", 64'(status), 64'(want.st));
                if (out_key !== want.key)
                    report_mismatch("out_key", 64'(out_key), 64'(want.key));
                if (out_name_head !== want.head)
                    report_mismatch("out_name_head", out_name_head, want.head);
                if (out_name_tail !== want.tail)
                    report_mismatch("out_name_tail", 64'(out_name_tail),
                                    64'(want.tail));
                if (last !== want.fin)
                    report_mismatch("last", 64'(last), 64'(want.fin));
            end
            results_seen <= results_seen + 1;
        end
    end

    // Guard against a hung block.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int n;
        logic [2:0] op;

        // Empty table: read-outs, delete and lookup all have nothing to find.
        add_item(OP_ASC, '0, '0, '0);
        add_item(OP_DESC, '0, '0, '0);
        add_item(OP_DELETE, '0, '0, '0);
        add_item(OP_LOOKUP, {KEY_W{1'b1}}, {HEAD_W{1'b1}}, {TAIL_W{1'b1}});
        // Key and name extremes.
        add_item(OP_INSERT, '0, '0, '0);
        add_item(OP_INSERT, {KEY_W{1'b1}}, {HEAD_W{1'b1}}, {TAIL_W{1'b1}});
        add_item(OP_INSERT, 27'd99999999, 64'h8000_0000_0000_0001, 8'h80);
        // Equal keys: the newer record goes in front.
        add_item(OP_INSERT, 27'd500, 64'h0123_4567_89AB_CDEF, 8'h5A);
        add_item(OP_INSERT, 27'd500, 64'hFEDC_BA98_7654_3210, 8'hA5);
        add_item(OP_LOOKUP, 27'd500, '0, '0);
        add_item(OP_LOOKUP, 27'd501, '0, '0);
        add_item(OP_ASC, '0, '0, '0);
        add_item(OP_DESC, '0, '0, '0);
        // Spare opcodes are ignored.
        add_item(OP_SPARE_FIRST, 27'd500, '0, '0);
        add_item(OP_SPARE_MID, 27'd500, '0, '0);
        add_item(OP_SPARE_LAST, '0, '0, '0);
        add_item(OP_DELETE, 27'd500, '0, '0);
        add_item(OP_LOOKUP, 27'd500, '0, '0);
        add_item(OP_DELETE, 27'd501, '0, '0);
        add_item(OP_DELETE, '0, '0, '0);
        add_item(OP_DELETE, {KEY_W{1'b1}}, '0, '0);
        add_item(OP_ASC, '0, '0, '0);

        // Random phases; spare opcodes are sprinkled in on top.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            op = pick_op(n);
            add_item(op, pick_key(), {$urandom, $urandom}, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 24) == 0)
                add_item(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), pick_key(),
                         {$urandom, $urandom}, 8'($urandom_range(0, 255)));
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for all items to go in and every predicted result to come out.
        while (pending_items.size() != 0 || in_valid || awaited_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
